>>> hdl/mlbc_pkg.sv
`default_nettype none

package mlbc_pkg;

    // Command codes carried in the input word's tuser.
    localparam int unsigned ACTION_W = 3;

    localparam logic [ACTION_W-1:0] ACT_TICK       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REGISTER   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ACTIVATE   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DEACTIVATE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SET_STILL  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_BUSY_SET   = 3'd5;

    // Field widths fixed by the stream format.
    localparam int unsigned LED_W      = 3;
    localparam int unsigned PERIOD_W   = 16;
    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned M_TDATA_W  = 8;

endpackage

`default_nettype wire

>>> hdl/mlbc_ram.sv
`default_nettype none

module mlbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hdl/multi_led_blink_controller_top.sv
// Multi-channel LED blink controller.
// The input stream carries one command per word: the command code in s_tuser and the slot,
// half-period, duration, level and busy flag in s_tdata. A tick command walks every slot in
// order and sends one word per slot on the output stream (slot, drive, pin level), with
// m_tlast set on the word for the final slot. Other commands produce no output words.
// The per-slot state sits in one synchronous RAM; each slot is read, updated and written back.
// A command other than a tick reads its slot, then modifies and writes it back; commands with
// an unknown code or a slot out of range are dropped. A tick issues the read of the first slot,
// then handles one slot per cycle while the receiver does not stall, with the read of the next
// slot overlapping the write of the current one. The first word follows the first slot's read.
// s_tready is high whenever no command is being worked on; a finished last word may still
// wait in the output register while the next command is taken.
// If the receiver stalls, the slot walk holds in place until the output register is free.
// Reset clears the per-slot registered flags at once, so all slots are unregistered and no
// clearing pass is needed; the RAM contents matter only once a slot is registered.
`default_nettype none

module multi_led_blink_controller_top #(
    parameter int NUM_LEDS    = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: led[2:0], period[18:3], duration[34:19], level[35], busy_on[36].
    input  wire logic [mlbc_pkg::S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0: action[2:0].
    input  wire logic [mlbc_pkg::ACTION_W-1:0]  s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // Fields from bit 0: slot[2:0], drive[3], pin_level[4].
    output logic      [mlbc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                                m_tlast
);

    import mlbc_pkg::*;

    localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int CW = COUNT_WIDTH;

    typedef struct packed {
        logic          busy_mode;
        logic [CW-1:0] busy_half_period;
        logic [CW-1:0] busy_count;
        logic [CW-1:0] blink_remaining;
        logic [CW-1:0] blink_count;
        logic [CW-1:0] blink_half_period;
        logic          current_level;
        logic          still_level;
    } slot_rec_t;

    localparam int REC_W = $bits(slot_rec_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMD,
        ST_TICK
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [NUM_LEDS-1:0]   present_reg, present_next;
    logic                  rd_present_reg, rd_present_next;
    logic [ACTION_W-1:0]   action_reg, action_next;
    logic [CW-1:0]         period_reg, period_next;
    logic [CW-1:0]         duration_reg, duration_next;
    logic                  level_reg, level_next;
    logic                  busy_on_reg, busy_on_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;
    logic                  m_last_reg, m_last_next;

    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    logic [REC_W-1:0]      mem_wr_data;
    logic                  mem_rd_en;
    logic [AW-1:0]         mem_rd_addr;
    logic [REC_W-1:0]      mem_rd_data;

    slot_rec_t             rec_cur;
    slot_rec_t             rec_new;
    logic                  tick_drive;
    logic                  tick_level;
    logic                  in_accept;
    logic [ACTION_W-1:0]   in_action;
    logic [LED_W-1:0]      in_led;
    logic                  led_in_range;
    logic                  out_free;
    logic                  last_slot;

    mlbc_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_LEDS)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign in_accept    = s_tvalid && s_tready;
    assign in_action    = s_tuser;
    assign in_led       = s_tdata[2:0];
    assign led_in_range = (32'(in_led) < 32'(NUM_LEDS));
    assign out_free     = !m_valid_reg || m_tready;
    assign last_slot    = (idx_reg == AW'(NUM_LEDS - 1));
    assign rec_cur      = slot_rec_t'(mem_rd_data);

    // One tick of the slot just read; an unregistered slot is left untouched.
    always_comb begin
        rec_new    = rec_cur;
        tick_drive = 1'b0;
        tick_level = 1'b0;
        if (rd_present_reg) begin
            if (rec_cur.busy_mode) begin
                if (rec_cur.busy_half_period != '0) begin
                    if (rec_cur.busy_count != '0) begin
                        rec_new.busy_count = rec_cur.busy_count - 1'b1;
                    end else begin
                        rec_new.busy_count    = rec_cur.busy_half_period - 1'b1;
                        rec_new.current_level = !rec_cur.current_level;
                    end
                end
                tick_drive = 1'b1;
                tick_level = rec_new.current_level;
            end else if (rec_cur.blink_remaining != '0) begin
                rec_new.blink_remaining = rec_cur.blink_remaining - 1'b1;
                if (rec_cur.blink_count != '0) begin
                    rec_new.blink_count = rec_cur.blink_count - 1'b1;
                end else begin
                    if (rec_cur.blink_half_period != '0) begin
                        rec_new.blink_count = rec_cur.blink_half_period - 1'b1;
                    end else begin
                        rec_new.blink_count = '0;
                    end
                    rec_new.current_level = !rec_cur.current_level;
                end
                tick_drive = 1'b1;
                tick_level = rec_new.current_level;
            end else if (rec_cur.blink_count != '0) begin
                // The half-period in flight runs out before the still level is shown.
                rec_new.blink_count = rec_cur.blink_count - 1'b1;
            end else begin
                tick_drive = 1'b1;
                tick_level = rec_cur.still_level;
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        present_next    = present_reg;
        rd_present_next = rd_present_reg;
        action_next     = action_reg;
        period_next     = period_reg;
        duration_next   = duration_reg;
        level_next      = level_reg;
        busy_on_next    = busy_on_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = idx_reg;
        mem_wr_data     = REC_W'(rec_new);
        mem_rd_en       = 1'b0;
        mem_rd_addr     = idx_reg;
        s_tready        = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    action_next   = in_action;
                    period_next   = CW'(s_tdata[18:3]);
                    duration_next = CW'(s_tdata[34:19]);
                    level_next    = s_tdata[35];
                    busy_on_next  = s_tdata[36];
                    if (in_action == ACT_TICK) begin
                        idx_next        = '0;
                        mem_rd_en       = 1'b1;
                        mem_rd_addr     = '0;
                        rd_present_next = present_reg[0];
                        state_next      = ST_TICK;
                    end else if (in_action <= ACT_BUSY_SET && led_in_range) begin
                        idx_next        = AW'(in_led);
                        mem_rd_en       = 1'b1;
                        mem_rd_addr     = AW'(in_led);
                        rd_present_next = present_reg[AW'(in_led)];
                        state_next      = ST_CMD;
                    end
                end
            end
            ST_CMD: begin
                slot_rec_t rec_cmd;
                rec_cmd    = rec_cur;
                state_next = ST_IDLE;
                mem_wr_en  = rd_present_reg;
                case (action_reg)
                    ACT_REGISTER: begin
                        rec_cmd               = '0;
                        rec_cmd.current_level = level_reg;
                        rec_cmd.still_level   = level_reg;
                        mem_wr_en             = 1'b1;
                        present_next[idx_reg] = 1'b1;
                    end
                    ACT_ACTIVATE: begin
                        rec_cmd.blink_count       = period_reg;
                        rec_cmd.blink_remaining   = duration_reg;
                        rec_cmd.blink_half_period = period_reg;
                        rec_cmd.current_level     = rec_cur.still_level;
                    end
                    ACT_DEACTIVATE: begin
                        rec_cmd.blink_count       = '0;
                        rec_cmd.blink_remaining   = '0;
                        rec_cmd.blink_half_period = '0;
                        rec_cmd.current_level     = rec_cur.still_level;
                    end
                    ACT_SET_STILL: begin
                        rec_cmd.still_level = level_reg;
                    end
                    ACT_BUSY_SET: begin
                        rec_cmd.busy_mode        = busy_on_reg;
                        rec_cmd.busy_count       = busy_on_reg ? period_reg : '0;
                        rec_cmd.busy_half_period = busy_on_reg ? period_reg : '0;
                        rec_cmd.current_level    = busy_on_reg && level_reg;
                    end
                    default: begin
                        mem_wr_en = 1'b0;
                    end
                endcase
                mem_wr_data = REC_W'(rec_cmd);
            end
            ST_TICK: begin
                // The read data for idx_reg holds while the output register is full.
                if (out_free) begin
                    mem_wr_en    = rd_present_reg;
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000, tick_level, tick_drive, 3'(idx_reg)};
                    m_last_next  = last_slot;
                    if (last_slot) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next        = idx_reg + 1'b1;
                        mem_rd_en       = 1'b1;
                        mem_rd_addr     = idx_reg + 1'b1;
                        rd_present_next = present_reg[idx_reg + 1'b1];
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            present_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            present_reg <= present_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg        <= idx_next;
        rd_present_reg <= rd_present_next;
        action_reg     <= action_next;
        period_reg     <= period_next;
        duration_reg   <= duration_next;
        level_reg      <= level_next;
        busy_on_reg    <= busy_on_next;
        m_data_reg     <= m_data_next;
        m_last_reg     <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire
